// ===== hw/rtl/ip_address_text_parser_core_macros.svh =====
// Assertion macros for the IP address text parser core.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef IP_ADDRESS_TEXT_PARSER_CORE_MACROS_SVH
`define IP_ADDRESS_TEXT_PARSER_CORE_MACROS_SVH

// Condition that must hold at every edge out of reset.
`define IPP_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define IPP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ipp_pkg.sv =====
// Shared types and constants for the IP address text parser.
// No dependencies; imported by every module of the block.
package ipp_pkg;

    localparam int MAX_LEN   = 1023;
    localparam int CNT_W     = $clog2(MAX_LEN + 2);
    localparam int CONS_W    = 11;
    localparam int ADDR_W    = 64;
    localparam int TDATA_W   = 144;
    localparam int TUSER_W   = 2;
    localparam int V4_FIELDS = 4;
    localparam int V6_GROUPS = 8;

    typedef enum logic [1:0] {
        ST_RUN     = 2'd0,
        ST_FAIL    = 2'd1,
        ST_OK      = 2'd2,
        ST_OKCLOSE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BR_FIRST  = 2'd0,
        BR_PLAIN  = 2'd1,
        BR_OPEN   = 2'd2,
        BR_REJECT = 2'd3
    } bracket_t;

    localparam logic [1:0] MODE_AUTO = 2'd0;
    localparam logic [1:0] MODE_V4   = 2'd1;
    localparam logic [1:0] MODE_V6   = 2'd2;

    localparam logic [1:0] CFG_ADDR_MODE = 2'd0;
    localparam logic [1:0] CFG_GROUP_SEP = 2'd1;
    localparam logic [1:0] CFG_BRACKET   = 2'd2;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_OPEN   = 8'h5B;
    localparam logic [7:0] CH_CLOSE  = 8'h5D;
    localparam logic [7:0] SEP_RESET = 8'h3A;

    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
        logic       last;
    } item_t;

    typedef struct packed {
        logic step;
        logic feed;
    } step_t;

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] length;
        logic [31:0]      bits;
    } v4_res_t;

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] length;
        logic [127:0]     bits;
    } v6_res_t;

    function automatic logic status_ok(status_t s);
        return (s == ST_OK) || (s == ST_OKCLOSE);
    endfunction

endpackage

// ===== hw/rtl/ipp_in_stage.sv =====
// Input register of the parser: holds one character request.
// Depends on ipp_pkg.
module ipp_in_stage
    import ipp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_ch,
    input  logic       in_last,
    input  logic       take,
    output item_t      item
);

    logic       valid_reg;
    logic [7:0] ch_reg;
    logic       last_reg;

    assign in_ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg   <= in_ch;
            last_reg <= in_last;
        end
    end

    assign item.valid = valid_reg;
    assign item.ch    = ch_reg;
    assign item.last  = last_reg;

endmodule

// ===== hw/rtl/ipp_v4.sv =====
// Dotted-quad IPv4 field parser: one character per step.
// Depends on ipp_pkg; result is the closed-out state for the final character.
module ipp_v4
    import ipp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  step_t   ctl,
    input  item_t   item,
    output v4_res_t res
);

    logic [1:0]       idx_reg, idx_next;
    logic [8:0]       value_reg, value_next;
    status_t          status_reg, status_next;
    logic [CNT_W-1:0] length_reg, length_next;
    logic [31:0]      bits_reg, bits_next;
    logic             seen_reg, seen_next;
    logic             is_digit;
    logic [11:0]      acc;

    localparam logic [1:0] LAST_FIELD = 2'(V4_FIELDS - 1);

    always_comb
    begin
        idx_next    = idx_reg;
        value_next  = value_reg;
        status_next = status_reg;
        length_next = length_reg;
        bits_next   = bits_reg;
        seen_next   = seen_reg;
        is_digit    = (item.ch >= 8'h30) && (item.ch <= 8'h39);
        acc         = ({3'b000, value_reg} << 3) + ({3'b000, value_reg} << 1)
                      + {8'h00, item.ch[3:0]};

        if (ctl.feed && (status_reg == ST_RUN))
        begin
            if (is_digit)
            begin
                value_next  = (acc > 12'd256) ? 9'd256 : acc[8:0];
                seen_next   = 1'b1;
                length_next = length_reg + 1'b1;
                if (acc > 12'd255)
                begin
                    status_next = ST_FAIL;
                end
            end
            else if ((item.ch == CH_DOT) && seen_reg && (idx_reg != LAST_FIELD))
            begin
                bits_next   = {bits_reg[23:0], value_reg[7:0]};
                idx_next    = idx_reg + 1'b1;
                value_next  = '0;
                seen_next   = 1'b0;
                length_next = length_reg + 1'b1;
            end
            else if ((idx_reg == LAST_FIELD) && seen_reg)
            begin
                bits_next   = {bits_reg[23:0], value_reg[7:0]};
                status_next = (item.ch == CH_CLOSE) ? ST_OKCLOSE : ST_OK;
            end
            else
            begin
                status_next = ST_FAIL;
            end
        end

        // close out at end of string
        res.status = status_next;
        res.length = length_next;
        res.bits   = bits_next;
        if (status_next == ST_RUN)
        begin
            if ((idx_next == LAST_FIELD) && seen_next)
            begin
                res.bits   = {bits_next[23:0], value_next[7:0]};
                res.status = ST_OK;
            end
            else
            begin
                res.status = ST_FAIL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            value_reg  <= '0;
            status_reg <= ST_RUN;
            length_reg <= '0;
            bits_reg   <= '0;
            seen_reg   <= 1'b0;
        end
        else if (ctl.step)
        begin
            if (item.last)
            begin
                idx_reg    <= '0;
                value_reg  <= '0;
                status_reg <= ST_RUN;
                length_reg <= '0;
                bits_reg   <= '0;
                seen_reg   <= 1'b0;
            end
            else
            begin
                idx_reg    <= idx_next;
                value_reg  <= value_next;
                status_reg <= status_next;
                length_reg <= length_next;
                bits_reg   <= bits_next;
                seen_reg   <= seen_next;
            end
        end
    end

endmodule

// ===== hw/rtl/ipp_v6.sv =====
// Full-form IPv6 group parser: eight hex groups, configurable separator.
// Depends on ipp_pkg; result is the closed-out state for the final character.
module ipp_v6
    import ipp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  step_t      ctl,
    input  item_t      item,
    input  logic [7:0] group_separator,
    output v6_res_t    res
);

    logic [2:0]       idx_reg, idx_next;
    logic [16:0]      value_reg, value_next;
    status_t          status_reg, status_next;
    logic [CNT_W-1:0] length_reg, length_next;
    logic [127:0]     bits_reg, bits_next;
    logic             seen_reg, seen_next;
    logic             is_hex;
    logic [3:0]       hex;
    logic [20:0]      acc;

    localparam logic [2:0] LAST_GROUP = 3'(V6_GROUPS - 1);

    always_comb
    begin
        is_hex = 1'b1;
        hex    = item.ch[3:0];
        if ((item.ch >= 8'h30) && (item.ch <= 8'h39))
        begin
            hex = item.ch[3:0];
        end
        else if (((item.ch >= 8'h61) && (item.ch <= 8'h66))
              || ((item.ch >= 8'h41) && (item.ch <= 8'h46)))
        begin
            hex = item.ch[3:0] + 4'd9;
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    always_comb
    begin
        idx_next    = idx_reg;
        value_next  = value_reg;
        status_next = status_reg;
        length_next = length_reg;
        bits_next   = bits_reg;
        seen_next   = seen_reg;
        acc         = {value_reg, hex};

        if (ctl.feed && (status_reg == ST_RUN))
        begin
            if (is_hex)
            begin
                value_next  = (acc > 21'h10000) ? 17'h10000 : acc[16:0];
                seen_next   = 1'b1;
                length_next = length_reg + 1'b1;
                if (acc > 21'h0FFFF)
                begin
                    status_next = ST_FAIL;
                end
            end
            else if (!seen_reg)
            begin
                status_next = ST_FAIL;
            end
            else
            begin
                bits_next = {bits_reg[111:0], value_reg[15:0]};
                if (idx_reg == LAST_GROUP)
                begin
                    status_next = (item.ch == CH_CLOSE) ? ST_OKCLOSE : ST_OK;
                end
                else if (item.ch == group_separator)
                begin
                    idx_next    = idx_reg + 1'b1;
                    value_next  = '0;
                    seen_next   = 1'b0;
                    length_next = length_reg + 1'b1;
                end
                else
                begin
                    status_next = ST_FAIL;
                end
            end
        end

        res.status = status_next;
        res.length = length_next;
        res.bits   = bits_next;
        if (status_next == ST_RUN)
        begin
            if ((idx_next == LAST_GROUP) && seen_next)
            begin
                res.bits   = {bits_next[111:0], value_next[15:0]};
                res.status = ST_OK;
            end
            else
            begin
                res.status = ST_FAIL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            value_reg  <= '0;
            status_reg <= ST_RUN;
            length_reg <= '0;
            bits_reg   <= '0;
            seen_reg   <= 1'b0;
        end
        else if (ctl.step)
        begin
            if (item.last)
            begin
                idx_reg    <= '0;
                value_reg  <= '0;
                status_reg <= ST_RUN;
                length_reg <= '0;
                bits_reg   <= '0;
                seen_reg   <= 1'b0;
            end
            else
            begin
                idx_reg    <= idx_next;
                value_reg  <= value_next;
                status_reg <= status_next;
                length_reg <= length_next;
                bits_reg   <= bits_next;
                seen_reg   <= seen_next;
            end
        end
    end

endmodule

// ===== hw/rtl/ipp_select.sv =====
// String framing (bracket check, length limit), result choice and output register.
// Depends on ipp_pkg; drives the step control of both parsers.
module ipp_select
    import ipp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  item_t              item,
    input  logic [1:0]         addr_mode,
    input  logic               bracket_mode,
    input  v4_res_t            v4_res,
    input  v6_res_t            v6_res,
    output step_t              ctl,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [TDATA_W-1:0] out_data,
    output logic [TUSER_W-1:0] out_user
);

    bracket_t         bracket_reg, bracket_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg;
    logic             ok_reg, ok_next;
    logic             kind_reg, kind_next;
    logic [CONS_W-1:0] cons_reg, cons_next;
    logic [ADDR_W-1:0] high_reg, high_next;
    logic [ADDR_W-1:0] low_reg, low_next;
    logic             advance;
    logic             feed;
    logic             ok4, ok6, pick6, ok;
    status_t          st;
    logic [CNT_W-1:0] len;

    assign advance = item.valid && (!item.last || !out_valid_reg || out_ready);

    always_comb
    begin
        bracket_next = bracket_reg;
        feed         = 1'b0;
        if (bracket_reg == BR_FIRST)
        begin
            if (bracket_mode)
            begin
                bracket_next = (item.ch == CH_OPEN) ? BR_OPEN : BR_REJECT;
            end
            else
            begin
                bracket_next = BR_PLAIN;
                feed         = 1'b1;
            end
        end
        else if (bracket_reg != BR_REJECT)
        begin
            feed = 1'b1;
        end
        count_next = (count_reg <= CNT_W'(MAX_LEN)) ? count_reg + 1'b1 : count_reg;
    end

    assign ctl.step = advance;
    assign ctl.feed = feed;

    always_comb
    begin
        ok4   = status_ok(v4_res.status);
        ok6   = status_ok(v6_res.status);
        ok    = 1'b0;
        pick6 = 1'b0;
        if ((bracket_next != BR_REJECT) && (count_next <= CNT_W'(MAX_LEN)))
        begin
            unique case (addr_mode)
                MODE_AUTO:
                begin
                    ok    = ok4 || ok6;
                    pick6 = !ok4;
                end
                MODE_V4:
                begin
                    ok    = ok4;
                    pick6 = 1'b0;
                end
                MODE_V6:
                begin
                    ok    = ok6;
                    pick6 = 1'b1;
                end
                default:
                begin
                    ok    = 1'b0;
                    pick6 = 1'b0;
                end
            endcase
        end
        st  = pick6 ? v6_res.status : v4_res.status;
        len = pick6 ? v6_res.length : v4_res.length;
        cons_next = CONS_W'(len);
        if (bracket_next == BR_OPEN)
        begin
            cons_next = CONS_W'(len) + CONS_W'(2);
            if (st != ST_OKCLOSE)
            begin
                ok = 1'b0;
            end
        end

        ok_next   = ok;
        kind_next = ok && pick6;
        high_next = '0;
        low_next  = '0;
        if (ok)
        begin
            if (pick6)
            begin
                high_next = v6_res.bits[127:64];
                low_next  = v6_res.bits[63:0];
            end
            else
            begin
                low_next = {32'h0, v4_res.bits};
            end
        end
        else
        begin
            cons_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bracket_reg   <= BR_FIRST;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                if (item.last)
                begin
                    bracket_reg <= BR_FIRST;
                    count_reg   <= '0;
                end
                else
                begin
                    bracket_reg <= bracket_next;
                    count_reg   <= count_next;
                end
            end
            if (advance && item.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item.last)
        begin
            ok_reg   <= ok_next;
            kind_reg <= kind_next;
            cons_reg <= cons_next;
            high_reg <= high_next;
            low_reg  <= low_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {(TDATA_W - CONS_W - 2 * ADDR_W)'(0), low_reg, high_reg, cons_reg};
    assign out_user  = {kind_reg, ok_reg};

endmodule

// ===== hw/rtl/ip_address_text_parser_core.sv =====
// IP address text parser, top level: configuration registers, input register,
// IPv4 and IPv6 parsers, result register. Depends on ipp_pkg and the macros header.
//
// Takes one character request per clock with no gaps needed between strings. A
// character passes an input register, then both parsers update their state and,
// on the final character, the chosen result is loaded into the result register:
// the result becomes valid when the result register loads, after the input register.
// Only the final character of a string waits on the result register; if a previous
// result is still untaken, input stalls until it is. Strings longer than MAX_LEN fail.
`include "ip_address_text_parser_core_macros.svh"

module ip_address_text_parser_core
    import ipp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    // character stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // ch
    input  logic               s_axis_tlast,
    // result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // consumed[10:0], addr_high, addr_low, pad
    output logic [TUSER_W-1:0] m_axis_tuser    // ok, kind
);

    logic [1:0] addr_mode_reg;
    logic [7:0] group_sep_reg;
    logic       bracket_mode_reg;
    item_t      item;
    step_t      ctl;
    v4_res_t    v4_res;
    v6_res_t    v6_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_mode_reg    <= MODE_AUTO;
            group_sep_reg    <= SEP_RESET;
            bracket_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ADDR_MODE: addr_mode_reg    <= cfg_data[1:0];
                CFG_GROUP_SEP: group_sep_reg    <= cfg_data;
                CFG_BRACKET:   bracket_mode_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    ipp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_ch    (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .take     (ctl.step),
        .item     (item)
    );

    ipp_v4 u_v4 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .item  (item),
        .res   (v4_res)
    );

    ipp_v6 u_v6 (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .item            (item),
        .group_separator (group_sep_reg),
        .res             (v6_res)
    );

    ipp_select u_select (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .addr_mode    (addr_mode_reg),
        .bracket_mode (bracket_mode_reg),
        .v4_res       (v4_res),
        .v6_res       (v6_res),
        .ctl          (ctl),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_user     (m_axis_tuser)
    );

    `IPP_ASSERT_ALWAYS(a_fail_zero, !(m_axis_tvalid && !m_axis_tuser[0]) || ((m_axis_tdata == '0) && !m_axis_tuser[1]), "failed result carries data")
    `IPP_ASSERT_ALWAYS(a_v4_upper_zero, !(m_axis_tvalid && m_axis_tuser[0] && !m_axis_tuser[1]) || ((m_axis_tdata[138:107] == '0) && (m_axis_tdata[74:11] == '0)), "IPv4 result has upper bits set")
    `IPP_ASSERT_NEXT(a_last_gives_result, ctl.step && item.last, m_axis_tvalid, "final character request gave no result")

endmodule

// ===== tb/sv/tb_ip_address_text_parser_core.sv =====
// Self-checking testbench for ip_address_text_parser_core: directed and random strings
// are parsed by an internal model and every result is compared field by field.
// Depends on ipp_pkg and the RTL of the core only.
module tb_ip_address_text_parser_core;
    import ipp_pkg::*;

    typedef struct packed {
        logic              ok;
        logic              kind;
        logic [CONS_W-1:0] consumed;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
    } parse_result_t;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         RANDOM_CHARS  = 120;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         MAX_REPORTS   = 10;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [7:0]         cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;   // ch
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;   // consumed[10:0], addr_high, addr_low, pad
    logic [TUSER_W-1:0] m_axis_tuser;   // ok, kind

    ip_address_text_parser_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // register mirror
    logic [1:0]   mode_reg;
    logic [7:0]   sep_reg;
    logic         br_reg;

    // per-string parse state
    int           v4_fld, v4_acc, v4_len;
    status_t      v4_st;
    logic [31:0]  v4_word;
    bit           v4_digits;
    int           v6_grp, v6_acc, v6_len;
    status_t      v6_st;
    logic [127:0] v6_word;
    bit           v6_digits;
    int           char_total;
    bracket_t     br_stage;

    parse_result_t expected_parses[$];
    logic [7:0]    line_buf[$];

    int mismatches    = 0;
    int chars_sent    = 0;
    int strings_sent  = 0;
    int parses_v4     = 0;
    int parses_v6     = 0;
    int parses_failed = 0;
    bit tx_steady     = 0;
    bit rx_steady     = 0;
    bit hold_request  = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_value(int unsigned hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return hi;
        return $urandom_range(0, hi);
    endfunction

    // ---------------------------------------------------------------- model

    function automatic void clear_parse();
        v4_fld = 0; v4_acc = 0; v4_len = 0; v4_st = ST_RUN; v4_word = '0; v4_digits = 0;
        v6_grp = 0; v6_acc = 0; v6_len = 0; v6_st = ST_RUN; v6_word = '0; v6_digits = 0;
        char_total = 0;
        br_stage = BR_FIRST;
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c - "0";
        if (c >= "a" && c <= "f")
            return c - "a" + 10;
        if (c >= "A" && c <= "F")
            return c - "A" + 10;
        return -1;
    endfunction

    function automatic void v4_feed_char(logic [7:0] c);
        if (v4_st != ST_RUN)
            return;
        if (c >= "0" && c <= "9")
        begin
            v4_acc = v4_acc * 10 + (c - "0");
            if (v4_acc > 256)
                v4_acc = 256;
            v4_digits = 1;
            v4_len++;
            if (v4_acc > 255)
                v4_st = ST_FAIL;
        end
        else if (c == CH_DOT && v4_digits && v4_fld < 3)
        begin
            v4_word = {v4_word[23:0], v4_acc[7:0]};
            v4_fld++;
            v4_acc = 0;
            v4_digits = 0;
            v4_len++;
        end
        else if (v4_fld == 3 && v4_digits)
        begin
            v4_word = {v4_word[23:0], v4_acc[7:0]};
            if (c == CH_CLOSE)
                v4_st = ST_OKCLOSE;
            else
                v4_st = ST_OK;
        end
        else
            v4_st = ST_FAIL;
    endfunction

    function automatic void v6_feed_char(logic [7:0] c);
        int d;
        if (v6_st != ST_RUN)
            return;
        d = hex_digit(c);
        if (d >= 0)
        begin
            v6_acc = (v6_acc << 4) | d;
            if (v6_acc > 'h10000)
                v6_acc = 'h10000;
            v6_digits = 1;
            v6_len++;
            if (v6_acc > 'hFFFF)
                v6_st = ST_FAIL;
            return;
        end
        if (!v6_digits)
        begin
            v6_st = ST_FAIL;
            return;
        end
        v6_word = {v6_word[111:0], v6_acc[15:0]};
        if (v6_grp == 7)
        begin
            if (c == CH_CLOSE)
                v6_st = ST_OKCLOSE;
            else
                v6_st = ST_OK;
        end
        else if (c == sep_reg)
        begin
            v6_grp++;
            v6_acc = 0;
            v6_digits = 0;
            v6_len++;
        end
        else
            v6_st = ST_FAIL;
    endfunction

    function automatic void predict_char(logic [7:0] c, logic lst);
        parse_result_t r;
        bit            ok4, ok6, pick6, good;
        status_t       st;
        int            len;
        if (char_total <= MAX_LEN)
            char_total++;
        if (br_stage == BR_FIRST)
        begin
            if (br_reg)
            begin
                if (c == CH_OPEN)
                    br_stage = BR_OPEN;
                else
                    br_stage = BR_REJECT;
            end
            else
            begin
                br_stage = BR_PLAIN;
                v4_feed_char(c);
                v6_feed_char(c);
            end
        end
        else if (br_stage != BR_REJECT)
        begin
            v4_feed_char(c);
            v6_feed_char(c);
        end
        if (!lst)
            return;

        // end of string closes whatever is still running
        if (v4_st == ST_RUN)
        begin
            if (v4_fld == 3 && v4_digits)
            begin
                v4_word = {v4_word[23:0], v4_acc[7:0]};
                v4_st = ST_OK;
            end
            else
                v4_st = ST_FAIL;
        end
        if (v6_st == ST_RUN)
        begin
            if (v6_grp == 7 && v6_digits)
            begin
                v6_word = {v6_word[111:0], v6_acc[15:0]};
                v6_st = ST_OK;
            end
            else
                v6_st = ST_FAIL;
        end

        ok4 = (v4_st == ST_OK) || (v4_st == ST_OKCLOSE);
        ok6 = (v6_st == ST_OK) || (v6_st == ST_OKCLOSE);
        good = 0;
        pick6 = 0;
        len = 0;
        if (br_stage != BR_REJECT && char_total <= MAX_LEN)
        begin
            case (mode_reg)
                MODE_AUTO:
                begin
                    good = ok4 || ok6;
                    pick6 = !ok4;
                end
                MODE_V4: good = ok4;
                MODE_V6:
                begin
                    good = ok6;
                    pick6 = 1;
                end
                default: good = 0;
            endcase
            if (good)
            begin
                if (pick6)
                begin
                    st = v6_st;
                    len = v6_len;
                end
                else
                begin
                    st = v4_st;
                    len = v4_len;
                end
                if (br_stage == BR_OPEN)
                begin
                    if (st != ST_OKCLOSE)
                        good = 0;
                    len += 2;
                end
            end
        end

        r = '0;
        if (good)
        begin
            r.ok = 1'b1;
            r.kind = pick6;
            r.consumed = len[CONS_W-1:0];
            r.addr_high = pick6 ? v6_word[127:64] : '0;
            r.addr_low = pick6 ? v6_word[63:0] : {32'd0, v4_word};
        end
        expected_parses.push_back(r);
        clear_parse();
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ADDR_MODE: mode_reg = val[1:0];
            CFG_GROUP_SEP: sep_reg = val;
            CFG_BRACKET:   br_reg = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_parses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic [1:0] mode, logic [7:0] sep, logic bracket);
        drain();
        write_reg(CFG_ADDR_MODE, {6'd0, mode});
        write_reg(CFG_GROUP_SEP, sep);
        write_reg(CFG_BRACKET, {7'd0, bracket});
    endtask

    task automatic send_char(logic [7:0] c, logic lst);
        int gap;
        gap = pick_gap(tx_steady);
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_char(c, lst);
        chars_sent++;
        if (lst)
            strings_sent++;
    endtask

    function automatic void put_byte(logic [7:0] c);
        line_buf.push_back(c);
    endfunction

    function automatic void put_str(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    task automatic send_line();
        int i;
        for (i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic send_text(string s);
        put_str(s);
        send_line();
    endtask

    // ---------------------------------------------------------------- generators

    function automatic void put_v4();
        int    fault, bad, n, i;
        int    v;
        string s;
        fault = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
        bad = $urandom_range(0, 3);
        n = (fault == 3) ? 3 : (fault == 4) ? 5 : 4;
        for (i = 0; i < n; i++)
        begin
            if (i > 0)
                put_byte(CH_DOT);
            if (fault == 2 && i == bad)
                continue;
            if (fault == 1 && i == bad)
                v = $urandom_range(0, 1) ? $urandom_range(256, 999)
                                         : $urandom_range(1000, 2000000000);
            else
                v = pick_value(255);
            s = $sformatf("%0d", v);
            if ($urandom_range(0, 7) == 0)
                s = {"0", s};
            put_str(s);
        end
    endfunction

    function automatic void put_v6();
        int          fault, bad, n, i;
        int unsigned v;
        string       s;
        fault = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0;
        bad = $urandom_range(0, 6);
        n = (fault == 3) ? 7 : (fault == 5) ? 9 : 8;
        for (i = 0; i < n; i++)
        begin
            if (i > 0)
                put_byte((fault == 4 && i == bad + 1) ? CH_DOT : sep_reg);
            if (fault == 2 && i == bad)
                continue;
            if (fault == 1 && i == bad)
                v = $urandom_range('h10000, 'hFFFFF);
            else
                v = pick_value('hFFFF);
            s = $sformatf("%0h", v);
            if ($urandom_range(0, 1))
                s = s.toupper();
            if ($urandom_range(0, 5) == 0)
                s = {"0", s};
            put_str(s);
        end
    endfunction

    function automatic void put_noise(int n);
        string pool;
        int    i;
        pool = "0123456789abcdefABCDEF.:[]-/ g";
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 1))
                put_byte(8'($urandom_range(0, 255)));
            else
                put_byte(pool[$urandom_range(0, pool.len() - 1)]);
        end
    endfunction

    task automatic send_random_string();
        int r;
        r = $urandom_range(0, 9);
        if (br_reg && $urandom_range(0, 7) != 0)
            put_byte(CH_OPEN);
        if (r < 4)
            put_v4();
        else if (r < 8)
            put_v6();
        else
            put_noise($urandom_range(1, 12));
        if (br_reg && $urandom_range(0, 5) != 0)
            put_byte(CH_CLOSE);
        if ($urandom_range(0, 2) == 0)
            put_noise($urandom_range(1, 4));
        send_line();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_ipv4_forms();
        send_text("0.0.0.0");
        send_text("255.255.255.255");
        send_text("256.0.0.1");
        send_text("99999999999.1.1.1");
        send_text("1..2.3");
        send_text("1.2.3");
        send_text(".1.2.3");
        send_text("192.168.001.010 trailing");
        send_text("7");
    endtask

    task automatic test_ipv6_forms();
        send_text("0:0:0:0:0:0:0:0");
        send_text("FFFF:ffff:ABCD:ef01:2345:6789:0:1");
        send_text("1:2:3:4:5:6:7:10000");
        send_text("1:2:3:4:5:6:7");
        send_text("1:2:3:4:5:6:7:8:9");
        send_text(":1:2:3:4:5:6:7");
    endtask

    task automatic test_modes();
        configure(MODE_V4, SEP_RESET, 1'b0);
        send_text("1:2:3:4:5:6:7:8");
        send_text("10.9.8.7");
        configure(MODE_V6, SEP_RESET, 1'b0);
        send_text("10.9.8.7");
        send_text("a:b:c:d:e:f:0:1");
        configure(MODE_UNUSED, SEP_RESET, 1'b0);
        send_text("10.9.8.7");
        send_text("a:b:c:d:e:f:0:1");
    endtask

    task automatic test_brackets();
        configure(MODE_AUTO, SEP_RESET, 1'b1);
        send_text("[10.0.0.1]");
        send_text("[10.0.0.1");
        send_text("10.0.0.1]");
        send_text("[1:2:3:4:5:6:7:8]x");
        send_text("[1:2:3:4:5:6:7:8");
        send_text("[");
        configure(MODE_V6, SEP_RESET, 1'b1);
        send_text("[ffff:0:0:0:0:0:0:ffff]");
    endtask

    task automatic send_fixed_v6(logic [7:0] sep);
        string grp[8] = '{"0", "ffff", "1a2B", "9", "0", "0", "7", "FFFF"};
        int    i;
        for (i = 0; i < 8; i++)
        begin
            if (i > 0)
                put_byte(sep);
            put_str(grp[i]);
        end
        send_line();
    endtask

    task automatic test_separators();
        // dot separator: both parsers can succeed on the same text
        configure(MODE_AUTO, CH_DOT, 1'b0);
        send_text("1.2.3.4.5.6.7.8");
        configure(MODE_AUTO, CH_DOT, 1'b1);
        send_text("[1.2.3.4.5.6.7.8]");
        configure(MODE_V6, CH_DOT, 1'b1);
        send_text("[1.2.3.4.5.6.7.8]");
        // a hex digit never separates
        configure(MODE_AUTO, "a", 1'b0);
        send_fixed_v6("a");
        configure(MODE_AUTO, 8'h00, 1'b0);
        send_fixed_v6(8'h00);
        configure(MODE_AUTO, 8'hFF, 1'b0);
        send_fixed_v6(8'hFF);
        configure(MODE_AUTO, SEP_RESET, 1'b0);
    endtask

    task automatic test_long_strings();
        // one character over the limit: a valid address at the front still fails
        tx_steady = 1;
        put_str("10.20.30.40 ");
        while (line_buf.size() < MAX_LEN + 1)
            put_byte(8'($urandom_range(0, 255)));
        send_line();
        tx_steady = 0;
    endtask

    task automatic test_backpressure();
        int i;
        drain();
        tx_steady = 1;
        hold_request = 1;
        for (i = 0; i < 6; i++)
            send_text("1.2.3.4");
        tx_steady = 0;
        drain();
    endtask

    task automatic test_random();
        int          target, r;
        logic [1:0]  mode;
        logic [7:0]  sep;
        target = chars_sent + RANDOM_CHARS;
        while (chars_sent < target)
        begin
            mode = ($urandom_range(0, 9) == 0) ? MODE_UNUSED
                                               : 2'($urandom_range(MODE_AUTO, MODE_V6));
            r = $urandom_range(0, 11);
            case (r)
                6:       sep = "-";
                7:       sep = CH_DOT;
                8:       sep = 8'h00;
                9:       sep = 8'hFF;
                10:      sep = 8'($urandom_range(0, 255));
                default: sep = SEP_RESET;
            endcase
            configure(mode, sep, $urandom_range(0, 3) == 0);
            tx_steady = $urandom_range(0, 3) == 0;
            rx_steady = $urandom_range(0, 3) == 0;
            repeat ($urandom_range(3, 8)) send_random_string();
        end
        tx_steady = 0;
        rx_steady = 0;
    endtask

    // ---------------------------------------------------------------- result side

    initial
    begin
        int stall, hold;
        stall = 0;
        hold = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold = HOLD_CYCLES;
                hold_request = 0;
            end
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall = pick_gap(rx_steady);
            end
        end
    end

    function automatic void note_mismatch(string what, parse_result_t want, parse_result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%t mismatch (%s): expected ok=%0b kind=%0b consumed=%0d hi=%h lo=%h, got ok=%0b kind=%0b consumed=%0d hi=%h lo=%h",
                     $realtime, what, want.ok, want.kind, want.consumed, want.addr_high,
                     want.addr_low, got.ok, got.kind, got.consumed, got.addr_high,
                     got.addr_low);
    endfunction

    always @(posedge clk)
    begin
        parse_result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.ok = m_axis_tuser[0];
            got.kind = m_axis_tuser[1];
            got.consumed = m_axis_tdata[CONS_W-1:0];
            got.addr_high = m_axis_tdata[CONS_W +: ADDR_W];
            got.addr_low = m_axis_tdata[CONS_W + ADDR_W +: ADDR_W];
            if (!got.ok)
                parses_failed++;
            else if (got.kind)
                parses_v6++;
            else
                parses_v4++;
            if (expected_parses.size() == 0)
                note_mismatch("nothing pending", '0, got);
            else
            begin
                want = expected_parses.pop_front();
                if (got !== want)
                    note_mismatch("field", want, got);
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        mode_reg = MODE_AUTO;
        sep_reg = SEP_RESET;
        br_reg = 1'b0;
        clear_parse();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_ipv4_forms();
        test_ipv6_forms();
        test_modes();
        test_brackets();
        test_separators();
        test_long_strings();
        test_backpressure();
        test_random();

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Parsed %0d strings, %0d characters: %0d IPv4, %0d IPv6, %0d rejected.",
                 strings_sent, chars_sent, parses_v4, parses_v6, parses_failed);
        $display("All address modes, brackets on/off, varied separators, long strings, %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && expected_parses.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ipp_pkg.sv
hw/rtl/ipp_in_stage.sv
hw/rtl/ipp_v4.sv
hw/rtl/ipp_v6.sv
hw/rtl/ipp_select.sv
hw/rtl/ip_address_text_parser_core.sv
tb/sv/tb_ip_address_text_parser_core.sv
